>>> sv/hls_pixel_tint_assert.svh
// Assertion macros for the checker file of the pixel tint block.
`ifndef HLS_PIXEL_TINT_ASSERT_SVH
`define HLS_PIXEL_TINT_ASSERT_SVH

// Checked at every clock edge outside reset.
`define HPT_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every clock edge, reset included.
`define HPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/hpt_pkg.sv
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 8;

  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int HUE_W      = 16;
  localparam int SAT_W      = 17;
  localparam int LSUM_W     = 9;

  localparam logic [PIX_W-1:0]  PIX_WHITE     = 24'hffffff;
  localparam logic [PIX_W-1:0]  PIX_WHITE_OUT = 24'hfefefe;
  localparam logic [SAT_W-1:0]  SAT_FULL      = 17'h10000;
  localparam logic [LSUM_W-1:0] LSUM_ONE      = 9'd255;
  localparam logic [LSUM_W-1:0] LSUM_TWO      = 9'd510;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TINT_HUE   = 2'd0,
    REG_TINT_SAT   = 2'd1,
    REG_WHITE_HACK = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEG_RAMP = 2'd0,
    SEG_HIGH = 2'd1,
    SEG_LOW  = 2'd2
  } seg_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic             white_hack;
  } cfg_t;

  // One classified pixel as handed from the front to the back.
  typedef struct packed {
    logic              white;
    logic [LSUM_W-1:0] lsum;
  } mid_entry_t;

endpackage

>>> sv/hpt_fifo.sv
module hpt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> sv/hpt_front.sv
module hpt_front (
  input  logic                     in_push,
  input  logic [hpt_pkg::PIX_W-1:0] in_pixel_rgb,
  output logic                     in_full,
  input  logic                     white_hack,
  input  logic                     mid_full,
  output logic                     mid_push,
  output hpt_pkg::mid_entry_t      mid_data
);
  import hpt_pkg::*;

  logic [CH_W-1:0] red, green, blue;
  logic [CH_W-1:0] ch_max, ch_min;

  assign red   = in_pixel_rgb[3*CH_W-1:2*CH_W];
  assign green = in_pixel_rgb[2*CH_W-1:CH_W];
  assign blue  = in_pixel_rgb[CH_W-1:0];

  always_comb begin
    ch_max = red;
    ch_min = red;
    if (green > ch_max) ch_max = green;
    if (blue > ch_max) ch_max = blue;
    if (green < ch_min) ch_min = green;
    if (blue < ch_min) ch_min = blue;
  end

  // Only max+min matters downstream; the white bypass is decided here.
  assign mid_data.lsum  = LSUM_W'(ch_max) + LSUM_W'(ch_min);
  assign mid_data.white = white_hack && (in_pixel_rgb == PIX_WHITE);
  assign in_full        = mid_full;
  assign mid_push       = in_push && !mid_full;

endmodule

>>> sv/hpt_back.sv
module hpt_back #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int OUT_DEPTH = hpt_pkg::OUT_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hpt_pkg::cfg_t             cfg,
  input  logic                      mid_empty,
  input  hpt_pkg::mid_entry_t       mid_data,
  output logic                      mid_pop,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [hpt_pkg::PIX_W-1:0] out_tinted_rgb
);
  import hpt_pkg::*;

  localparam int FB    = FRAC_BITS;
  localparam int LW    = FB + 1;
  localparam int PW    = 2 * LW;
  localparam int XS    = FB + 4;
  localparam int UP    = (FB >= HUE_W) ? FB - HUE_W : 0;
  localparam int DN    = (FB < HUE_W) ? HUE_W - FB : 0;
  localparam int HALF  = 1 << (FB - 1);
  localparam int OCC_W = $clog2(OUT_DEPTH + 1);

  localparam logic [LW-1:0] ONE       = LW'(1) << FB;
  localparam logic [LW-1:0] HALF_L    = LW'(HALF);
  localparam logic [LW-1:0] KC        = LW'(HALF / 255);
  localparam logic [15:0]   RC        = 16'(HALF % 255);
  localparam logic [XS-1:0] X_ONE     = XS'(1) << FB;
  localparam logic [XS-1:0] X_TWO     = XS'(2) << FB;
  localparam logic [XS-1:0] X_THREE   = XS'(3) << FB;
  localparam logic [XS-1:0] X_FOUR    = XS'(4) << FB;
  localparam logic [XS-1:0] X_SIX     = XS'(6) << FB;

  // Issue control: items in the pipe plus items in the result queue never
  // exceed its depth, so the pipe itself never has to stall.
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             issue, out_take;

  assign issue    = !mid_empty && (occ_r < OCC_W'(OUT_DEPTH));
  assign mid_pop  = issue;
  assign out_take = out_pop && !out_empty;
  assign occ_nxt  = occ_r + OCC_W'(issue) - OCC_W'(out_take);

  // Tint values derived from the registers; the user must keep them static while items are in flight.
  logic [SAT_W-1:0]      sat_c;
  logic [SAT_W+UP-1:0]   sat_w;
  logic [LW-1:0]         sf;
  logic [HUE_W+UP-1:0]   hue_w;
  logic [FB-1:0]         hf;
  logic [XS-1:0]         h6;
  logic [XS-1:0]         hoff [3];
  logic [XS-1:0]         hsum [3];
  logic [XS-1:0]         hx   [3];
  logic [LW-1:0]         ht   [3];
  seg_t                  hseg [3];

  assign sat_c = (cfg.sat > SAT_FULL) ? SAT_FULL : cfg.sat;
  assign sat_w = (SAT_W + UP)'(sat_c) << UP;
  assign sf    = LW'(sat_w >> DN);
  assign hue_w = (HUE_W + UP)'(cfg.hue) << UP;
  assign hf    = FB'(hue_w >> DN);
  assign h6    = XS'(hf) * XS'(6);

  // Channel 0 is red, 1 green, 2 blue.
  assign hoff[0] = X_TWO;
  assign hoff[1] = '0;
  assign hoff[2] = X_FOUR;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      hsum[c] = h6 + hoff[c];
      hx[c]   = (hsum[c] >= X_SIX) ? hsum[c] - X_SIX : hsum[c];
      if (hx[c] < X_ONE) begin
        hseg[c] = SEG_RAMP;
        ht[c]   = LW'(hx[c]);
      end else if (hx[c] < X_THREE) begin
        hseg[c] = SEG_HIGH;
        ht[c]   = '0;
      end else if (hx[c] < X_FOUR) begin
        hseg[c] = SEG_RAMP;
        ht[c]   = LW'(X_FOUR - hx[c]);
      end else begin
        hseg[c] = SEG_LOW;
        ht[c]   = '0;
      end
    end
  end

  // Stage A: split max+min into a multiple of 255 and a remainder, so that
  // ceil(sum * ONE / 510) becomes two small constant products.
  logic          a_v_r;
  logic          a_white_r, a_white_nxt;
  logic [LW-1:0] a_base_r, a_base_nxt;
  logic [15:0]   a_y_r, a_y_nxt;
  logic [LW-1:0] a_qpart;
  logic [7:0]    a_r0;

  always_comb begin
    if (mid_data.lsum >= LSUM_TWO) begin
      a_qpart = ONE;
      a_r0    = '0;
    end else if (mid_data.lsum >= LSUM_ONE) begin
      a_qpart = HALF_L;
      a_r0    = 8'(mid_data.lsum - LSUM_ONE);
    end else begin
      a_qpart = '0;
      a_r0    = mid_data.lsum[7:0];
    end
    a_base_nxt  = a_qpart + LW'(a_r0) * KC;
    a_y_nxt     = 16'(a_r0) * RC;
    a_white_nxt = mid_data.white;
  end

  // Stage B: lightness, adding the rounded-up remainder over 255.
  logic          b_v_r;
  logic          b_white_r;
  logic [LW-1:0] b_l_r, b_l_nxt;
  logic [16:0]   b_z, b_q;

  always_comb begin
    b_z     = 17'(a_y_r) + 17'd254;
    b_q     = (b_z + (b_z >> 8) + 17'd1) >> 8;
    b_l_nxt = a_base_r + LW'(b_q[7:0]);
  end

  // Stage C: L * S / ONE.
  logic          c_v_r;
  logic          c_white_r;
  logic [LW-1:0] c_l_r;
  logic [LW-1:0] c_p_r, c_p_nxt;
  logic [PW-1:0] c_prod;

  always_comb begin
    c_prod  = PW'(b_l_r) * PW'(sf);
    c_p_nxt = c_prod[FB+LW-1:FB];
  end

  // Stage D: the two HLS levels M2 and M1.
  logic          d_v_r;
  logic          d_white_r;
  logic [LW-1:0] d_m1_r, d_m1_nxt;
  logic [LW-1:0] d_d_r, d_d_nxt;
  logic [LW:0]   d_two_l, d_m2_raw, d_m1_raw;
  logic [LW-1:0] d_m2;

  always_comb begin
    d_two_l = {c_l_r, 1'b0};
    if (d_two_l <= (LW + 1)'(ONE)) begin
      d_m2_raw = (LW + 1)'(c_l_r) + (LW + 1)'(c_p_r);
    end else begin
      d_m2_raw = (LW + 1)'(c_l_r) + (LW + 1)'(sf) - (LW + 1)'(c_p_r);
    end
    d_m2     = (d_m2_raw > (LW + 1)'(ONE)) ? ONE : LW'(d_m2_raw);
    d_m1_raw = (d_two_l >= (LW + 1)'(d_m2)) ? d_two_l - (LW + 1)'(d_m2) : '0;
    d_m1_nxt = (d_m1_raw > (LW + 1)'(d_m2)) ? d_m2 : LW'(d_m1_raw);
    d_d_nxt  = d_m2 - d_m1_nxt;
  end

  // Stage E: ramp products, one per channel.
  logic          e_v_r;
  logic          e_white_r;
  logic [LW-1:0] e_m1_r;
  logic [LW-1:0] e_d_r;
  logic [PW-1:0] e_prod      [3];
  logic [LW-1:0] e_ramp_nxt  [3];
  logic [LW-1:0] e_ramp_r    [3];
  seg_t          e_seg_r     [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_prod[c]     = PW'(d_d_r) * PW'(ht[c]);
      e_ramp_nxt[c] = e_prod[c][FB+LW-1:FB];
    end
  end

  // Final step: level per channel, scaled to 8 bits, into the result queue.
  logic [LW:0]       f_val [3];
  logic [LW-1:0]     f_cl  [3];
  logic [FB+8:0]     f_sc  [3];
  logic [CH_W-1:0]   f_ch  [3];
  logic [PIX_W-1:0]  f_pix;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (e_seg_r[c])
        SEG_RAMP: f_val[c] = (LW + 1)'(e_m1_r) + (LW + 1)'(e_ramp_r[c]);
        SEG_HIGH: f_val[c] = (LW + 1)'(e_m1_r) + (LW + 1)'(e_d_r);
        SEG_LOW:  f_val[c] = (LW + 1)'(e_m1_r);
        default:  f_val[c] = (LW + 1)'(e_m1_r);
      endcase
      f_cl[c] = (f_val[c] > (LW + 1)'(ONE)) ? ONE : LW'(f_val[c]);
      f_sc[c] = ((FB + 9)'(f_cl[c]) << 8) - (FB + 9)'(f_cl[c]);
      f_ch[c] = f_sc[c][FB+7:FB];
    end
    f_pix = e_white_r ? PIX_WHITE_OUT : {f_ch[0], f_ch[1], f_ch[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      a_v_r <= issue;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_base_r  <= a_base_nxt;
    a_y_r     <= a_y_nxt;
    a_white_r <= a_white_nxt;
    b_l_r     <= b_l_nxt;
    b_white_r <= a_white_r;
    c_l_r     <= b_l_r;
    c_p_r     <= c_p_nxt;
    c_white_r <= b_white_r;
    d_m1_r    <= d_m1_nxt;
    d_d_r     <= d_d_nxt;
    d_white_r <= c_white_r;
    e_m1_r    <= d_m1_r;
    e_d_r     <= d_d_r;
    e_white_r <= d_white_r;
    for (int c = 0; c < 3; c++) begin
      e_ramp_r[c] <= e_ramp_nxt[c];
      e_seg_r[c]  <= hseg[c];
    end
  end

  hpt_fifo #(
    .WIDTH (PIX_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (e_v_r),
    .din   (f_pix),
    .full  (),
    .pop   (out_pop),
    .dout  (out_tinted_rgb),
    .empty (out_empty)
  );

endmodule

>>> sv/hls_pixel_tint.sv
// HLS pixel tint. Each 24-bit RGB pixel is reduced to its HLS lightness and
// rebuilt with the programmed tint hue and saturation; with white_hack set,
// pure white comes out as 0xfefefe. The block sustains one pixel per clock:
// a new pixel can be pushed every cycle as long as results are popped at the
// same pace. A pixel pushed into an idle block passes the input queue, the five
// register stages of the tint pipeline and the write into the result queue on
// its way to the result ports. A four-entry input queue and an eight-entry
// result queue absorb stalls on either side. The pipeline only takes a pixel
// when a result queue slot is free for it, so when results are not popped the
// block keeps taking pixels until twelve are held: four in the input queue
// and eight in the pipeline and result queue together.
// Registers are written through the cfg port (always ready) and must only be
// changed while no pixel is in flight.
module hls_pixel_tint #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int MID_DEPTH = hpt_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = hpt_pkg::OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [hpt_pkg::PIX_W-1:0]      in_pixel_rgb,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [hpt_pkg::PIX_W-1:0]      out_tinted_rgb,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import hpt_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       mid_push, mid_full, mid_pop, mid_empty;
  mid_entry_t mid_in, mid_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TINT_HUE:   cfg_nxt.hue        = cfg_wdata[HUE_W-1:0];
        REG_TINT_SAT:   cfg_nxt.sat        = cfg_wdata[SAT_W-1:0];
        REG_WHITE_HACK: cfg_nxt.white_hack = cfg_wdata[0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hpt_front u_front (
    .in_push      (in_push),
    .in_pixel_rgb (in_pixel_rgb),
    .in_full      (in_full),
    .white_hack   (cfg_r.white_hack),
    .mid_full     (mid_full),
    .mid_push     (mid_push),
    .mid_data     (mid_in)
  );

  hpt_fifo #(
    .WIDTH ($bits(mid_entry_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .din   (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_out),
    .empty (mid_empty)
  );

  hpt_back #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .mid_empty      (mid_empty),
    .mid_data       (mid_out),
    .mid_pop        (mid_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_tinted_rgb (out_tinted_rgb)
  );

endmodule

>>> sv/hpt_checker.sv
`include "hls_pixel_tint_assert.svh"

module hpt_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_push,
  input logic                      in_full,
  input logic                      out_empty,
  input logic                      out_pop,
  input logic [hpt_pkg::PIX_W-1:0] out_tinted_rgb
);

  // Both queues come out of reset empty.
  `HPT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> out_empty && !in_full, "queues not empty after reset")

  // A waiting result stays put until it is taken.
  `HPT_ASSERT_RUN(a_out_hold, !out_empty && !out_pop |=> !out_empty && $stable(out_tinted_rgb), "result changed while not popped")

  // Results only drain through a pop transaction or a reset.
  `HPT_ASSERT_RUN(a_empty_by_pop, $rose(out_empty) |-> $past(out_pop) || !$past(rst_n), "result queue emptied without a pop")

  // The input side fills up only through a push transaction.
  `HPT_ASSERT_RUN(a_full_by_push, $rose(in_full) |-> $past(in_push), "input queue filled without a push")

endmodule

bind hls_pixel_tint hpt_checker u_hpt_checker (.*);

>>> tb/sv/hpt_tint_checker.sv
// Watches the pixel, result and register channels of the tint block. Each accepted
// pixel is turned into the expected tinted pixel at once, and every popped result
// is compared with the oldest expected one.
module hpt_tint_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  input  logic                           in_full,
  input  logic [hpt_pkg::PIX_W-1:0]      in_pixel_rgb,
  input  logic                           out_empty,
  input  logic                           out_pop,
  input  logic [hpt_pkg::PIX_W-1:0]      out_tinted_rgb,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    failures,
  output int unsigned                    outstanding,
  output int unsigned                    results_checked
);
  import hpt_pkg::*;

  localparam int          FB   = FRAC_BITS_DEF;
  localparam int unsigned UP   = (FB >= 16) ? FB - 16 : 0;
  localparam int unsigned DOWN = (FB < 16) ? 16 - FB : 0;
  localparam logic [63:0] ONE  = 64'd1 << FB;

  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;
  logic             white_hack_q;
  logic [PIX_W-1:0] tinted_q [$];

  function automatic logic [63:0] q16_to_frac(input logic [63:0] v);
    return (v << UP) >> DOWN;
  endfunction

  // Level of one channel on the HLS hue wheel, then scaled to 8 bits.
  function automatic logic [7:0] wheel_channel(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [63:0] x);
    logic [63:0] span;
    logic [63:0] level;
    span = hi - lo;
    if (x < ONE)
      level = lo + (span * x) / ONE;
    else if (x < 3 * ONE)
      level = hi;
    else if (x < 4 * ONE)
      level = lo + (span * (4 * ONE - x)) / ONE;
    else
      level = lo;
    if (level > ONE)
      level = ONE;
    level = (level * 64'd255) / ONE;
    return level[7:0];
  endfunction

  function automatic logic [PIX_W-1:0] tint_pixel(input logic [PIX_W-1:0] pix);
    logic [7:0]  r, g, b, top_c, bot_c;
    logic [63:0] csum, light, sat, h6, m1, m2, six;
    six = 6 * ONE;
    if (white_hack_q && pix == PIX_WHITE)
      return PIX_WHITE_OUT;
    r = pix[23:16];
    g = pix[15:8];
    b = pix[7:0];
    top_c = r;
    bot_c = r;
    if (g > top_c) top_c = g;
    if (b > top_c) top_c = b;
    if (g < bot_c) bot_c = g;
    if (b < bot_c) bot_c = b;
    csum = top_c;
    csum = csum + bot_c;
    light = ((csum << FB) + 64'd509) / 64'd510;
    sat = (sat_q > SAT_FULL) ? SAT_FULL : sat_q;
    sat = q16_to_frac(sat);
    h6 = 6 * q16_to_frac(hue_q);
    if (h6 >= six)
      h6 = six - 1;
    if (2 * light <= ONE)
      m2 = (light * (ONE + sat)) / ONE;
    else
      m2 = light + sat - (light * sat) / ONE;
    if (m2 > ONE)
      m2 = ONE;
    m1 = (2 * light >= m2) ? 2 * light - m2 : 64'd0;
    if (m1 > m2)
      m1 = m2;
    return {wheel_channel(m1, m2, (h6 + 2 * ONE) % six),
            wheel_channel(m1, m2, h6),
            wheel_channel(m1, m2, (h6 + 4 * ONE) % six)};
  endfunction

  task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("[%0t] %s: tinted_rgb got %06h, expected %06h", $time, what, got, want);
    failures++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hue_q = '0;
      sat_q = '0;
      white_hack_q = 1'b0;
      tinted_q.delete();
      failures = 0;
      results_checked <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TINT_HUE:   hue_q = cfg_wdata[HUE_W-1:0];
          REG_TINT_SAT:   sat_q = cfg_wdata[SAT_W-1:0];
          REG_WHITE_HACK: white_hack_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full)
        tinted_q.push_back(tint_pixel(in_pixel_rgb));
      if (out_pop && !out_empty) begin
        if (tinted_q.size() == 0) begin
          report_mismatch("result with no pixel pending", out_tinted_rgb, 'x);
        end else begin
          if (out_tinted_rgb !== tinted_q[0])
            report_mismatch("wrong tinted pixel", out_tinted_rgb, tinted_q[0]);
          void'(tinted_q.pop_front());
          results_checked <= results_checked + 1;
        end
      end
    end
    outstanding <= tinted_q.size();
  end

endmodule

>>> tb/sv/tb_hls_pixel_tint.sv
module tb_hls_pixel_tint;
  import hpt_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_PIXELS = 152;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned LIMIT_CYCLES = 600000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic [PIX_W-1:0]      in_pixel_rgb = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic [PIX_W-1:0]      out_tinted_rgb;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned failures, outstanding, results_checked;
  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_armed = 1'b0;
  logic        hold_taken = 1'b0;

  // Grays, primaries, white and its neighbor, and both sides of half lightness.
  logic [PIX_W-1:0] probe_pixels [12] = '{
    24'h000000, 24'hffffff, 24'hfefefe, 24'h808080, 24'h7f7f7f, 24'hff0000,
    24'h00ff00, 24'h0000ff, 24'h010000, 24'hff00ff, 24'h80ff00, 24'h123456
  };

  hls_pixel_tint i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel_rgb   (in_pixel_rgb),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_tinted_rgb (out_tinted_rgb),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  hpt_tint_checker u_tint_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_pixel_rgb    (in_pixel_rgb),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_tinted_rgb  (out_tinted_rgb),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .failures        (failures),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles with %0d results outstanding", cycles, outstanding);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stalls, and one long hold-off that lets the block fill up.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_taken) begin
      out_pop <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      out_pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] corner_level();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h7f;
      3: return 8'h80;
      4: return 8'hfe;
      default: return 8'hff;
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [31:0] word;
    word = $urandom;
    case ($urandom_range(7))
      0: return PIX_WHITE;
      1: return {word[7:0], word[7:0], word[7:0]};
      2: return {corner_level(), corner_level(), corner_level()};
      default: return word[PIX_W-1:0];
    endcase
  endfunction

  // Push stays high from one transaction to the next unless a gap is drawn.
  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    in_push <= 1'b1;
    in_pixel_rgb <= pix;
    do @(posedge clk); while (in_full);
    pixels_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Unused data bits carry noise so the block must mask them off.
  task automatic program_tint(input logic [HUE_W-1:0] hue, input logic [SAT_W-1:0] sat,
                              input logic wh, input logic poke_unused);
    logic [31:0] noise;
    noise = $urandom;
    put_reg(REG_TINT_HUE, {noise[0], hue});
    put_reg(REG_TINT_SAT, sat);
    put_reg(REG_WHITE_HACK, {noise[16:1], wh});
    if (poke_unused)
      put_reg(REG_UNUSED, noise[31:15]);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    logic [31:0]      word;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] sat;
    logic             wh;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels first under the reset settings, then with white hack on.
    foreach (probe_pixels[k]) send_pixel(probe_pixels[k]);
    wait_idle();
    program_tint(16'd43691, SAT_FULL, 1'b1, 1'b0);
    foreach (probe_pixels[k]) send_pixel(probe_pixels[k]);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      word = $urandom;
      case (phase)
        0: begin hue = 16'd0;     sat = 17'd0;      wh = 1'b0; end
        1: begin hue = 16'hffff;  sat = SAT_FULL;   wh = 1'b1; end
        2: begin hue = 16'd32768; sat = 17'h1ffff;  wh = 1'b0; end
        3: begin hue = 16'd10923; sat = 17'd32768;  wh = 1'b1; end
        4: begin hue = 16'd21845; sat = 17'd65535;  wh = 1'b0; end
        5: begin hue = 16'd54613; sat = 17'd100000; wh = 1'b1; end
        default: begin
          hue = word[15:0];
          sat = SAT_W'($urandom_range(131071));
          if (!word[31] && sat > SAT_FULL)
            sat = sat - SAT_FULL;
          wh = word[30];
        end
      endcase
      program_tint(hue, sat, wh, (phase % 3) == 0);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 54; end
        default: begin send_idle_pct = 24; recv_stall_pct <= 24; end
      endcase
      if (phase == 2)
        hold_armed <= 1'b1;

      repeat (PHASE_PIXELS) send_pixel(random_pixel());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d pixels sent, %0d results checked, under %0d register settings",
             pixels_sent, results_checked, settings_used);
    $display("settings spanned hue and saturation extremes, white hack both ways, stalls");
    if (failures == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
